FILE: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, sizes and the per-item context record for the rotation
// matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package rmq_pkg;
  localparam int EW = 32;
  localparam int DW = 34;
  localparam int ROOTW = 64;
  localparam int QW = 64;

  function automatic int rad_width(int frac);
    return (frac + 3 > 35) ? frac + 3 : 35;
  endfunction

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_W = 2'd3
  } sel_t;

  typedef struct packed {
    logic             degen;
    sel_t             sel;
    logic [2:0][DW-1:0] num;
  } ctx_t;
endpackage
`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Shepperd rotation matrix to unit quaternion, fixed point, deep pipeline.
//
//  channel  dir  payload
//  in_      in   tdata: e00..e22, 9 x 32 bits
//  out_     out  tdata: qx, qy, qz, qw(31), degenerate
//
//  One item per cycle unless the output stalls. After the front register come
//  (RADW+FRAC_BITS+1)/2 square root stages, (33+FRAC_BITS) divider stages
//  and 1 output stage. Synchronous active-low reset clears the valid bits
//  only. A stall freezes the whole pipe in place.
// ----------------------------------------------------------------------------
`default_nettype none
module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 30
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [287:0] in_tdata,   // e00,e01,e02,e10,e11,e12,e20,e21,e22
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [127:0] out_tdata   // qx,qy,qz,qw[30:0],degenerate
);
  localparam int RADW = rmq_pkg::rad_width(FRAC_BITS);
  localparam int SQ = (RADW + FRAC_BITS + 1) / 2;
  localparam int LAT = 1 + SQ + (rmq_pkg::DW - 1 + FRAC_BITS) + 1;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [RADW-1:0] rad;
  rmq_pkg::ctx_t c0, c1;
  logic [rmq_pkg::ROOTW-1:0] root;
  logic [3:0][rmq_pkg::EW-1:0] q;
  logic degen;

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .en(en), .m(in_tdata), .rad_r(rad), .ctx_r(c0));
  rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk(clk), .en(en), .rad(rad), .ctx_i(c0), .root(root), .ctx_o(c1));
  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .en(en), .root(root), .ctx_i(c1), .q_o(q), .degen_o(degen));

  assign out_tdata = {degen, q[3][30:0], q[2], q[1], q[0]};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed during stall");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[127] |-> out_tdata[126:0] == '0)
    else $error("degenerate result not zero");
endmodule
`default_nettype wire

FILE: rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection, radicand and off-diagonal numerators. One register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_front #(
  parameter int FRAC_BITS = 30
) (
  input  wire logic                                      clk,
  input  wire logic                                      en,
  input  wire logic [8:0][rmq_pkg::EW-1:0]               m,
  output      logic [rmq_pkg::rad_width(FRAC_BITS)-1:0]  rad_r,
  output      rmq_pkg::ctx_t                             ctx_r
);
  localparam int RADW = rmq_pkg::rad_width(FRAC_BITS);

  logic signed [RADW-1:0] a0, a4, a8, a1, a2, a3, a5, a6, a7, tr, one, rad;
  rmq_pkg::ctx_t ctx_nxt;

  always_comb begin
    a0 = RADW'($signed(m[0])); a1 = RADW'($signed(m[1]));
    a2 = RADW'($signed(m[2])); a3 = RADW'($signed(m[3]));
    a4 = RADW'($signed(m[4])); a5 = RADW'($signed(m[5]));
    a6 = RADW'($signed(m[6])); a7 = RADW'($signed(m[7]));
    a8 = RADW'($signed(m[8]));
    one = RADW'(1) << FRAC_BITS;
    tr = a0 + a4 + a8;
    ctx_nxt = '0;
    if (tr > 0) begin
      ctx_nxt.sel = rmq_pkg::SEL_W;
      rad = tr + one;
      ctx_nxt.num[0] = rmq_pkg::DW'(a7 - a5);
      ctx_nxt.num[1] = rmq_pkg::DW'(a2 - a6);
      ctx_nxt.num[2] = rmq_pkg::DW'(a3 - a1);
    end else if (a0 > a4 && a0 > a8) begin
      ctx_nxt.sel = rmq_pkg::SEL_X;
      rad = one + a0 - a4 - a8;
      ctx_nxt.num[0] = rmq_pkg::DW'(a1 + a3);
      ctx_nxt.num[1] = rmq_pkg::DW'(a2 + a6);
      ctx_nxt.num[2] = rmq_pkg::DW'(a7 - a5);
    end else if (a4 > a8) begin
      ctx_nxt.sel = rmq_pkg::SEL_Y;
      rad = one + a4 - a0 - a8;
      ctx_nxt.num[0] = rmq_pkg::DW'(a1 + a3);
      ctx_nxt.num[1] = rmq_pkg::DW'(a5 + a7);
      ctx_nxt.num[2] = rmq_pkg::DW'(a2 - a6);
    end else begin
      ctx_nxt.sel = rmq_pkg::SEL_Z;
      rad = one + a8 - a0 - a4;
      ctx_nxt.num[0] = rmq_pkg::DW'(a2 + a6);
      ctx_nxt.num[1] = rmq_pkg::DW'(a5 + a7);
      ctx_nxt.num[2] = rmq_pkg::DW'(a3 - a1);
    end
    ctx_nxt.degen = (rad <= 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= ctx_nxt.degen ? '0 : rad;
      ctx_r <= ctx_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring square root of rad * 2^FRAC_BITS, one root bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_sqrt #(
  parameter int FRAC_BITS = 30
) (
  input  wire logic                                      clk,
  input  wire logic                                      en,
  input  wire logic [rmq_pkg::rad_width(FRAC_BITS)-1:0]  rad,
  input  wire rmq_pkg::ctx_t                             ctx_i,
  output      logic [rmq_pkg::ROOTW-1:0]                 root,
  output      rmq_pkg::ctx_t                             ctx_o
);
  localparam int NW = rmq_pkg::rad_width(FRAC_BITS) + FRAC_BITS;
  localparam int RB = (NW + 1) / 2;
  localparam int RW = RB + 2;

  logic [RB:0][NW-1:0]   n_r;
  logic [RB:0][RW-1:0]   rem_r;
  logic [RB:0][RB-1:0]   q_r;
  rmq_pkg::ctx_t [RB:0]  c_r;

  always_comb begin
    n_r[0]   = NW'(rad) << FRAC_BITS;
    rem_r[0] = '0;
    q_r[0]   = '0;
    c_r[0]   = ctx_i;
  end

  for (genvar i = 0; i < RB; i++) begin : g_st
    localparam int B = RB - 1 - i;
    logic [RW-1:0] rs, tv;
    logic [1:0] pair;
    always_comb begin
      pair = (2 * B + 1 < NW) ? 2'(n_r[i] >> (2 * B)) : {1'b0, n_r[i][2 * B]};
      rs = {rem_r[i][RW-3:0], pair};
      tv = {q_r[i][RW-3:0], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1] <= n_r[i];
        c_r[i+1] <= c_r[i];
        if (rs >= tv) begin
          rem_r[i+1] <= rs - tv;
          q_r[i+1]   <= {q_r[i][RB-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= rs;
          q_r[i+1]   <= {q_r[i][RB-2:0], 1'b0};
        end
      end
    end
  end

  assign root  = rmq_pkg::ROOTW'(q_r[RB]);
  assign ctx_o = c_r[RB];
endmodule
`default_nettype wire

FILE: rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Three parallel pipelined restoring dividers, floor(|num| * 2^FRAC_BITS / S)
// with S = 2 * root, one quotient bit a stage, then sign, flip and saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_div #(
  parameter int FRAC_BITS = 30
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [rmq_pkg::ROOTW-1:0] root,
  input  wire rmq_pkg::ctx_t             ctx_i,
  output      logic [3:0][rmq_pkg::EW-1:0] q_o,
  output      logic                      degen_o
);
  localparam int NB = rmq_pkg::DW - 1 + FRAC_BITS;
  localparam int DV = rmq_pkg::ROOTW + 1;
  localparam int RW = DV + 1;
  localparam int CW = (NB > rmq_pkg::QW + 1) ? NB : rmq_pkg::QW + 1;

  logic [NB:0][DV-1:0]          d_r;
  logic [NB:0][rmq_pkg::ROOTW-1:0] rt_r;
  logic [NB:0][2:0][NB-1:0]     nm_r;
  logic [NB:0][2:0][RW-1:0]     rm_r;
  logic [NB:0][2:0][NB-1:0]     qq_r;
  logic [NB:0][2:0]             sg_r;
  logic [NB:0][1:0]             sl_r;
  logic [NB:0]                  dg_r;

  always_comb begin
    d_r[0]  = {root, 1'b0};
    rt_r[0] = root;
    sl_r[0] = ctx_i.sel;
    dg_r[0] = ctx_i.degen;
    for (int k = 0; k < 3; k++) begin
      sg_r[0][k] = ctx_i.num[k][rmq_pkg::DW-1];
      nm_r[0][k] = NB'(sg_r[0][k] ? -ctx_i.num[k] : ctx_i.num[k]) << FRAC_BITS;
      rm_r[0][k] = '0;
      qq_r[0][k] = '0;
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_st
    logic [2:0][RW-1:0] rs;
    always_comb begin
      for (int k = 0; k < 3; k++) rs[k] = {rm_r[i][k][RW-2:0], nm_r[i][k][NB-1-i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i+1] <= d_r[i]; rt_r[i+1] <= rt_r[i];
        nm_r[i+1] <= nm_r[i]; sg_r[i+1] <= sg_r[i];
        sl_r[i+1] <= sl_r[i]; dg_r[i+1] <= dg_r[i];
        for (int k = 0; k < 3; k++) begin
          if (rs[k] >= RW'(d_r[i])) begin
            rm_r[i+1][k] <= rs[k] - RW'(d_r[i]);
            qq_r[i+1][k] <= {qq_r[i][k][NB-2:0], 1'b1};
          end else begin
            rm_r[i+1][k] <= rs[k];
            qq_r[i+1][k] <= {qq_r[i][k][NB-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic signed [rmq_pkg::QW:0] sq [3];
  logic signed [rmq_pkg::QW:0] qv [4];
  logic signed [rmq_pkg::QW:0] big, cap;
  logic [CW-1:0] qe [3];
  logic [CW-1:0] ce;
  logic [1:0] s;
  logic flip;
  logic [3:0][rmq_pkg::EW-1:0] q_nxt;

  always_comb begin
    cap = (rmq_pkg::QW+1)'(1) << 62;
    ce = CW'(1) << 62;
    s = sl_r[NB];
    big = (rmq_pkg::QW+1)'(rt_r[NB] >> 1);
    for (int k = 0; k < 3; k++) begin
      qe[k] = CW'(qq_r[NB][k]);
      sq[k] = (d_r[NB] == '0 || qe[k] > ce) ? cap
             : (rmq_pkg::QW+1)'(qq_r[NB][k]);
      if (sg_r[NB][k]) sq[k] = -sq[k];
    end
    unique case (s)
      rmq_pkg::SEL_W: begin qv[0] = sq[0]; qv[1] = sq[1]; qv[2] = sq[2]; qv[3] = big; end
      rmq_pkg::SEL_X: begin qv[0] = big; qv[1] = sq[0]; qv[2] = sq[1]; qv[3] = sq[2]; end
      rmq_pkg::SEL_Y: begin qv[0] = sq[0]; qv[1] = big; qv[2] = sq[1]; qv[3] = sq[2]; end
      default:        begin qv[0] = sq[0]; qv[1] = sq[1]; qv[2] = big; qv[3] = sq[2]; end
    endcase
    flip = qv[3] < 0;
    for (int k = 0; k < 4; k++) begin
      if (flip) qv[k] = -qv[k];
      if (dg_r[NB]) q_nxt[k] = '0;
      else if (qv[k] > 33'sh0_7FFF_FFFF) q_nxt[k] = 32'h7FFF_FFFF;
      else if (qv[k] < -33'sh0_8000_0000) q_nxt[k] = 32'h8000_0000;
      else q_nxt[k] = qv[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_o     <= q_nxt;
      degen_o <= dg_r[NB];
    end
  end
endmodule
`default_nettype wire

FILE: test/rotation_matrix_to_quaternion_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quaternion result checker
// Watches the matrix and quaternion streams, computes the expected
// quaternion for every accepted matrix and compares it field by field.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_checker #(
  parameter int FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [287:0] in_tdata,   // e00,e01,e02,e10,e11,e12,e20,e21,e22
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,  // qx,qy,qz,qw[30:0],degenerate
  output int           fail_count,
  output int           pending
);
  localparam logic [63:0] QCAP = 64'd1 << 62;

  typedef struct packed {
    logic        degenerate;
    logic [30:0] qw;
    logic [31:0] qz;
    logic [31:0] qy;
    logic [31:0] qx;
  } quat_t;

  quat_t quat_queue[$];

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 61; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] div_frac(logic signed [63:0] num, logic [63:0] d);
    logic [63:0] mag;
    logic [127:0] q;
    mag = num < 0 ? 64'(-num) : 64'(num);
    if (d == 0) q = QCAP;
    else begin
      q = ({64'd0, mag} << FRAC_BITS) / {64'd0, d};
      if (q > QCAP) q = QCAP;
    end
    return num < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic quat_t matrix_to_quat(logic [287:0] data);
    logic signed [63:0] m[9];
    logic signed [63:0] one, tr, rad, big;
    logic signed [63:0] q[4];
    logic [63:0] root, s;
    rmq_pkg::sel_t sel;
    quat_t r;
    one = 64'sd1 <<< FRAC_BITS;
    for (int k = 0; k < 9; k++) m[k] = $signed(data[32*k +: 32]);
    tr = m[0] + m[4] + m[8];
    if (tr > 0) begin
      sel = rmq_pkg::SEL_W; rad = tr + one;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      sel = rmq_pkg::SEL_X; rad = one + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      sel = rmq_pkg::SEL_Y; rad = one + m[4] - m[0] - m[8];
    end else begin
      sel = rmq_pkg::SEL_Z; rad = one + m[8] - m[0] - m[4];
    end
    r = '0;
    if (rad <= 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    root = isqrt({64'd0, rad} << FRAC_BITS);
    s = root << 1;
    big = $signed(root >> 1);
    case (sel)
      rmq_pkg::SEL_W: begin
        q[0] = div_frac(m[7] - m[5], s); q[1] = div_frac(m[2] - m[6], s);
        q[2] = div_frac(m[3] - m[1], s); q[3] = big;
      end
      rmq_pkg::SEL_X: begin
        q[0] = big; q[1] = div_frac(m[1] + m[3], s);
        q[2] = div_frac(m[2] + m[6], s); q[3] = div_frac(m[7] - m[5], s);
      end
      rmq_pkg::SEL_Y: begin
        q[0] = div_frac(m[1] + m[3], s); q[1] = big;
        q[2] = div_frac(m[5] + m[7], s); q[3] = div_frac(m[2] - m[6], s);
      end
      default: begin
        q[0] = div_frac(m[2] + m[6], s); q[1] = div_frac(m[5] + m[7], s);
        q[2] = big; q[3] = div_frac(m[3] - m[1], s);
      end
    endcase
    if (q[3] < 0) for (int k = 0; k < 4; k++) q[k] = -q[k];
    r.qx = sat32(q[0]);
    r.qy = sat32(q[1]);
    r.qz = sat32(q[2]);
    r.qw = q[3] > 64'sh7FFFFFFF ? 31'h7FFFFFFF : q[3][30:0];
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch %s got %h expected %h", $realtime, field, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = quat_queue.size();

  always @(posedge clk) begin
    quat_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) quat_queue.push_back(matrix_to_quat(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (quat_queue.size() == 0) report("unexpected", got.qx, 32'd0);
        else begin
          want = quat_queue.pop_front();
          if (got.qx !== want.qx) report("qx", got.qx, want.qx);
          if (got.qy !== want.qy) report("qy", got.qy, want.qy);
          if (got.qz !== want.qz) report("qz", got.qz, want.qz);
          if (got.qw !== want.qw) report("qw", 32'(got.qw), 32'(want.qw));
          if (got.degenerate !== want.degenerate)
            report("degenerate", 32'(got.degenerate), 32'(want.degenerate));
        end
      end
    end
  end
endmodule

FILE: test/rotation_matrix_to_quaternion_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion testbench
// Sends directed and random matrices with random gaps and back-pressure,
// including one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top_test;
  localparam int FRAC_BITS = 30;
  localparam int NUM_RANDOM = 500;
  localparam int LATENCY = 1 + (35 + FRAC_BITS + 1) / 2 + 33 + FRAC_BITS + 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  bit           stim_done = 1'b0;
  logic [287:0] matrix_list[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC_BITS)) i_dut (.*);

  rotation_matrix_to_quaternion_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (.*);

  function automatic logic [287:0] pack9(logic [31:0] a0, a1, a2, a3, a4, a5, a6, a7, a8);
    return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  function automatic logic [287:0] rand_matrix();
    logic [287:0] r;
    logic [31:0] d;
    for (int k = 0; k < 9; k++) r[32*k +: 32] = rand_entry();
    if ($urandom_range(0, 3) == 0) begin
      d = rand_entry();
      r[0 +: 32] = d; r[128 +: 32] = d;
      if ($urandom_range(0, 1)) r[256 +: 32] = d;
    end
    return r;
  endfunction

  initial begin
    matrix_list.push_back(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    matrix_list.push_back(pack9(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    matrix_list.push_back(pack9(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    matrix_list.push_back(pack9(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
    matrix_list.push_back(pack9(0, 0, 0, 0, 0, 0, 0, 0, 0));
    matrix_list.push_back(pack9(-ONE, 5, 7, 9, -ONE, 3, 2, 1, -ONE));
    matrix_list.push_back(pack9(-ONE/2, 1, 2, 3, -ONE/2, 4, 5, 6, -ONE/2));
    matrix_list.push_back(pack9(-2*ONE, 0, 0, 0, -2*ONE, 0, 0, 0, 4));
    matrix_list.push_back(pack9('1, '1, '1, '1, '1, '1, '1, '1, '1));
    matrix_list.push_back(pack9(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                32'h7FFFFFFF));
    matrix_list.push_back(pack9(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                32'h80000000));
    matrix_list.push_back(pack9(0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0,
                                32'h80000000, 32'h80000000, 32'h7FFFFFFF, -1));
    matrix_list.push_back(pack9(1, 2, 3, 4, -1, 5, 6, 7, 0));
    matrix_list.push_back(pack9(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE));
    matrix_list.push_back(pack9(ONE, 0, 0, 0, 0, ONE, 0, -ONE, 0));
    matrix_list.push_back(pack9(-5, 1, 1, 1, -5, 1, 1, 1, -7));
    for (int i = 0; i < NUM_RANDOM; i++) matrix_list.push_back(rand_matrix());
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (matrix_list[i]) begin
      repeat ($urandom_range(0, 7) * ($urandom_range(0, 3) != 0)) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= matrix_list[i];
      do @(posedge clk); while (!in_tready);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    @(posedge rst_n);
    repeat (40 + 3 * LATENCY) @(posedge clk);
    forever begin
      repeat ($urandom_range(0, 7)) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    if (pending == 0) repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0 && !out_tvalid) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT && !stim_done);
    $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: rotation_matrix_to_quaternion_top.f
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion_top.sv
test/rotation_matrix_to_quaternion_checker.sv
test/rotation_matrix_to_quaternion_top_test.sv
